[hw/rtl/pcf_pkg.sv]
`timescale 1ns / 1ps

package pcf_pkg;

  // Default depth of the id table
  localparam int TABLE_DEPTH_DEF = 256;

  // Field widths
  localparam int CMD_W      = 3;
  localparam int BYTE_W     = 8;
  localparam int CP_W       = 21;
  localparam int ID_W       = 10;
  localparam int POS_W      = 16;
  localparam int TS_W       = 9;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_START  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_BYTE   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_CLAUSE = 3'd2;
  localparam logic [CMD_W-1:0] CMD_FINISH = 3'd3;
  localparam logic [CMD_W-1:0] CMD_LOAD   = 3'd4;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TABLE_SIZE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_IDS    = 2'd1;

  // Fixed ids
  localparam logic [ID_W-1:0] ID_PAD = 10'd0;
  localparam logic [ID_W-1:0] ID_BOS = 10'd1;
  localparam logic [ID_W-1:0] ID_EOS = 10'd2;

  // Characters of interest
  localparam logic [BYTE_W-1:0] CH_LPAREN = 8'h28;
  localparam logic [BYTE_W-1:0] CH_RPAREN = 8'h29;
  localparam logic [BYTE_W-1:0] CH_SPACE  = 8'h20;
  localparam logic [BYTE_W-1:0] CH_PERIOD = 8'h2E;
  localparam logic [BYTE_W-1:0] CH_COMMA  = 8'h2C;
  localparam logic [BYTE_W-1:0] CH_QUEST  = 8'h3F;
  localparam logic [BYTE_W-1:0] CH_EXCL   = 8'h21;
  localparam logic [BYTE_W-1:0] CH_COLON  = 8'h3A;
  localparam logic [BYTE_W-1:0] CH_SEMI   = 8'h3B;

  // One table entry: codepoint key and its id
  typedef struct packed {
    logic [CP_W-1:0] cp;
    logic [ID_W-1:0] id;
  } tab_entry_t;

  // Lookup request to the search unit
  typedef struct packed {
    logic            start;
    logic [CP_W-1:0] key;
  } srch_req_t;

  // Lookup result; done pulses for one cycle
  typedef struct packed {
    logic            done;
    logic            found;
    logic [ID_W-1:0] id;
  } srch_res_t;

  function automatic logic is_punct(input logic [BYTE_W-1:0] c);
    return (c == CH_PERIOD) || (c == CH_COMMA) || (c == CH_QUEST) ||
           (c == CH_EXCL) || (c == CH_COLON) || (c == CH_SEMI);
  endfunction

  // Punctuation that is followed by a space id
  function automatic logic is_pause(input logic [BYTE_W-1:0] c);
    return (c == CH_COMMA) || (c == CH_COLON) || (c == CH_SEMI);
  endfunction

endpackage

[hw/rtl/pcf_ram.sv]
`timescale 1ns / 1ps

module pcf_ram #(
  parameter int WIDTH = 31,
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write one entry, read one registered
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[hw/rtl/pcf_search.sv]
`timescale 1ns / 1ps

module pcf_search import pcf_pkg::*; #(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
  localparam int AW = $clog2(TABLE_DEPTH)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [TS_W-1:0]  table_size,
  input  srch_req_t        req,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  tab_entry_t       wr_data,
  output srch_res_t        res
);

  localparam int NW = AW + 1;
  localparam int CW = (NW > TS_W) ? NW : TS_W;
  localparam int EW = $bits(tab_entry_t);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_CMP  = 1'b1;

  logic            state_r, state_nxt;
  logic [NW-1:0]   lo_r, hi_r, mid_r;
  logic [CP_W-1:0] key_r;
  logic            match_r;
  logic [ID_W-1:0] mid_id_r;
  logic            done_r, found_r;
  logic [ID_W-1:0] id_r;

  logic [CW-1:0]   ts_x;
  logic [NW-1:0]   n;
  logic [NW-1:0]   init_mid;
  logic [EW-1:0]   rd_raw;
  tab_entry_t      rd;
  logic            lt, eq;
  logic [NW-1:0]   lo_c, hi_c, mid_c;
  logic [NW:0]     sum_c;
  logic [AW-1:0]   raddr;
  logic            more;

  // Clamp the entry count to the table depth
  assign ts_x     = CW'(table_size);
  assign n        = (ts_x > CW'(TABLE_DEPTH)) ? NW'(TABLE_DEPTH) : ts_x[NW-1:0];
  assign init_mid = n >> 1;

  pcf_ram #(
    .WIDTH (EW),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .raddr (raddr),
    .rdata (rd_raw)
  );

  assign rd = tab_entry_t'(rd_raw);

  // One probe a cycle: compare, narrow the range, issue the next address
  assign lt    = rd.cp < key_r;
  assign eq    = rd.cp == key_r;
  assign lo_c  = lt ? (mid_r + NW'(1)) : lo_r;
  assign hi_c  = lt ? hi_r : mid_r;
  assign sum_c = {1'b0, lo_c} + {1'b0, hi_c};
  assign mid_c = sum_c[NW:1];
  assign more  = lo_c < hi_c;
  assign raddr = (state_r == S_IDLE) ? init_mid[AW-1:0] : mid_c[AW-1:0];

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (req.start && (n != '0)) begin
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        if (!more) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      unique case (state_r)
        S_IDLE: begin
          done_r <= req.start && (n == '0);
          if (req.start) begin
            key_r   <= req.key;
            lo_r    <= '0;
            hi_r    <= n;
            mid_r   <= init_mid;
            match_r <= 1'b0;
            // Empty table: report a miss at once
            if (n == '0) begin
              found_r <= 1'b0;
            end
          end
        end
        S_CMP: begin
          lo_r   <= lo_c;
          hi_r   <= hi_c;
          mid_r  <= mid_c;
          done_r <= !more;
          // Remember the lowest entry not below the key
          if (!lt) begin
            match_r  <= eq;
            mid_id_r <= rd.id;
          end
          if (!more) begin
            found_r <= lt ? match_r : eq;
            id_r    <= lt ? mid_id_r : rd.id;
          end
        end
        default: done_r <= 1'b0;
      endcase
    end
  end

  assign res = '{done: done_r, found: found_r, id: id_r};

  a_cmp_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CMP) |-> ((lo_r < hi_r) && (mid_r >= lo_r) && (mid_r < hi_r)))
    else $error("search probe outside its range");

  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CMP) |-> !req.start)
    else $error("lookup started while a search is running");

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> (state_r == S_IDLE))
    else $error("lookup result while a search is running");

endmodule

[hw/rtl/phoneme_codepoint_to_id_framer_core.sv]
`timescale 1ns / 1ps

// Phoneme codepoint-to-id framer.
// Input channel (in_valid/in_ready): one command item per handshake: start,
// phoneme byte, clause end, finish or table load. Bytes are UTF-8 decoded,
// text in parentheses is skipped and each codepoint is looked up in the
// loaded sorted table by a binary search. Each hit gives its id and a pad.
// Output channel (out_valid/out_ready): one id per item with its position in
// the sequence; out_last marks the final id caused by an input item.
// Config port (cfg_valid/cfg_ready, always ready): index 0 table_size,
// index 1 max_ids; write only while the block is idle.
// Timing: one input item at a time. The search unit and its table RAM port
// give one probe per cycle. A comma, colon or semicolon runs two searches
// back to back.
// Reset clears the decoder, the parenthesis flag, the id count and the
// registers (table_size 0, max_ids 65535); table contents are undefined
// until loaded. A stalled receiver holds the output register; the block
// takes the next item once its ids have moved into that register.

module phoneme_codepoint_to_id_framer_core import pcf_pkg::*; #(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [CMD_W-1:0]      in_cmd,
  input  logic [BYTE_W-1:0]     in_data_byte,
  input  logic [BYTE_W-1:0]     in_punctuation_char,
  input  logic [BYTE_W-1:0]     in_entry_index,
  input  logic [CP_W-1:0]       in_entry_codepoint,
  input  logic [ID_W-1:0]       in_entry_id,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [ID_W-1:0]       out_phoneme_id,
  output logic [POS_W-1:0]      out_position,
  output logic                  out_last,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int XW = (AW + 1 > BYTE_W + 1) ? AW + 1 : BYTE_W + 1;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SRCH = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]       state_r, state_nxt;
  logic [POS_W-1:0] wc_r;
  logic [CP_W-1:0]  acc_r, acc_nxt;
  logic [1:0]       cont_r, cont_nxt;
  logic             paren_r;
  logic [TS_W-1:0]  ts_r;
  logic [POS_W-1:0] max_r;
  logic             pause_r, ph1_r, f0_r;
  logic [ID_W-1:0]  id0_r;
  logic [ID_W-1:0]  q_r [4];
  logic [2:0]       qn_r;
  logic             out_valid_r, out_last_r;
  logic [ID_W-1:0]  out_id_r;
  logic [POS_W-1:0] out_pos_r;

  logic             in_fire, out_load;
  logic             cp_v, is_lp, is_rp;
  logic [CP_W-1:0]  cp;
  logic             cap_eos, cap_start;
  logic             a_f, b_f, c_a, c_b;
  logic [ID_W-1:0]  a_id;
  logic [POS_W-1:0] wc_a;
  logic             second_lookup;
  logic [XW-1:0]    idx_x;
  logic             wr_en;
  srch_req_t        srch_req;
  srch_res_t        srch_res;

  assign in_fire   = in_valid && in_ready;
  assign in_ready  = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_load  = !out_valid_r || out_ready;

  // UTF-8 decode of one byte
  always_comb begin
    acc_nxt  = acc_r;
    cont_nxt = cont_r;
    cp_v     = 1'b0;
    cp       = CP_W'(in_data_byte);
    if (cont_r != 2'd0) begin
      acc_nxt  = {acc_r[CP_W-7:0], in_data_byte[5:0]};
      cont_nxt = cont_r - 2'd1;
      cp_v     = (cont_r == 2'd1);
      cp       = acc_nxt;
    end else if (!in_data_byte[7]) begin
      cp_v = 1'b1;
    end else if (in_data_byte[7:5] == 3'b110) begin
      acc_nxt  = CP_W'(in_data_byte[4:0]);
      cont_nxt = 2'd1;
    end else if (in_data_byte[7:4] == 4'b1110) begin
      acc_nxt  = CP_W'(in_data_byte[3:0]);
      cont_nxt = 2'd2;
    end else if (in_data_byte[7:3] == 5'b11110) begin
      acc_nxt  = CP_W'(in_data_byte[2:0]);
      cont_nxt = 2'd3;
    end else begin
      // stray continuation byte or invalid lead byte stands for itself
      cp_v = 1'b1;
    end
  end

  assign is_lp = (cp == CP_W'(CH_LPAREN));
  assign is_rp = (cp == CP_W'(CH_RPAREN));

  // Capacity checks
  assign cap_start = (max_r >= POS_W'(2));
  assign cap_eos   = ({1'b0, wc_r} + (POS_W + 1)'(1)) <= {1'b0, max_r};

  // Plan the ids of a finished lookup (one pair, or two for a pause mark)
  assign second_lookup = !ph1_r && pause_r;
  assign a_f  = ph1_r ? f0_r : srch_res.found;
  assign a_id = ph1_r ? id0_r : srch_res.id;
  assign b_f  = ph1_r && srch_res.found;
  assign c_a  = a_f && (({1'b0, wc_r} + (POS_W + 1)'(2)) <= {1'b0, max_r});
  assign wc_a = c_a ? (wc_r + POS_W'(2)) : wc_r;
  assign c_b  = b_f && (({1'b0, wc_a} + (POS_W + 1)'(2)) <= {1'b0, max_r});

  // Table load
  assign idx_x = XW'(in_entry_index);
  assign wr_en = in_fire && (in_cmd == CMD_LOAD) && (idx_x < XW'(TABLE_DEPTH));

  // Sequencer next state and lookup requests
  always_comb begin
    state_nxt      = state_r;
    srch_req.start = 1'b0;
    srch_req.key   = cp;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          unique case (in_cmd)
            CMD_START: begin
              if (cap_start) state_nxt = ST_EMIT;
            end
            CMD_BYTE: begin
              if (cp_v && !is_lp && !is_rp && !paren_r) begin
                srch_req.start = 1'b1;
                state_nxt      = ST_SRCH;
              end
            end
            CMD_CLAUSE: begin
              srch_req.key = CP_W'(in_punctuation_char);
              if (is_punct(in_punctuation_char)) begin
                srch_req.start = 1'b1;
                state_nxt      = ST_SRCH;
              end
            end
            CMD_FINISH: begin
              if (cap_eos) state_nxt = ST_EMIT;
            end
            default: ;
          endcase
        end
      end
      ST_SRCH: begin
        if (srch_res.done) begin
          if (second_lookup) begin
            srch_req.start = 1'b1;
            srch_req.key   = CP_W'(CH_SPACE);
          end else if (c_a || c_b) begin
            state_nxt = ST_EMIT;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_EMIT: begin
        if (out_load && (qn_r == 3'd1)) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  pcf_search #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_search (
    .clk        (clk),
    .rst_n      (rst_n),
    .table_size (ts_r),
    .req        (srch_req),
    .wr_en      (wr_en),
    .wr_addr    (idx_x[AW-1:0]),
    .wr_data    ('{cp: in_entry_codepoint, id: in_entry_id}),
    .res        (srch_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      wc_r    <= '0;
      acc_r   <= '0;
      cont_r  <= 2'd0;
      paren_r <= 1'b0;
      ts_r    <= '0;
      max_r   <= '1;
      qn_r    <= 3'd0;
      pause_r <= 1'b0;
      ph1_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;

      // Configuration writes
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_TABLE_SIZE: ts_r  <= cfg_data[TS_W-1:0];
          CFG_MAX_IDS:    max_r <= cfg_data[POS_W-1:0];
          default: ;
        endcase
      end

      unique case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            unique case (in_cmd)
              CMD_START: begin
                wc_r    <= '0;
                acc_r   <= '0;
                cont_r  <= 2'd0;
                paren_r <= 1'b0;
                q_r[0]  <= ID_BOS;
                q_r[1]  <= ID_PAD;
                qn_r    <= 3'd2;
              end
              CMD_BYTE: begin
                acc_r   <= acc_nxt;
                cont_r  <= cont_nxt;
                pause_r <= 1'b0;
                ph1_r   <= 1'b0;
                if (cp_v && is_lp) paren_r <= 1'b1;
                else if (cp_v && is_rp) paren_r <= 1'b0;
              end
              CMD_CLAUSE: begin
                // drop any partial sequence
                acc_r   <= '0;
                cont_r  <= 2'd0;
                paren_r <= 1'b0;
                pause_r <= is_pause(in_punctuation_char);
                ph1_r   <= 1'b0;
              end
              CMD_FINISH: begin
                q_r[0] <= ID_EOS;
                qn_r   <= 3'd1;
              end
              default: ;
            endcase
          end
        end
        ST_SRCH: begin
          if (srch_res.done) begin
            if (second_lookup) begin
              ph1_r <= 1'b1;
              f0_r  <= srch_res.found;
              id0_r <= srch_res.id;
            end else begin
              q_r[0] <= c_a ? a_id : srch_res.id;
              q_r[1] <= ID_PAD;
              q_r[2] <= srch_res.id;
              q_r[3] <= ID_PAD;
              qn_r   <= {c_a && c_b, c_a ^ c_b, 1'b0};
            end
          end
        end
        ST_EMIT: begin
          // advance the queue as each id moves out
          if (out_load) begin
            q_r[0] <= q_r[1];
            q_r[1] <= q_r[2];
            q_r[2] <= q_r[3];
            qn_r   <= qn_r - 3'd1;
            wc_r   <= wc_r + POS_W'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((state_r == ST_EMIT) && out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == ST_EMIT) && out_load) begin
      out_id_r   <= q_r[0];
      out_pos_r  <= wc_r;
      out_last_r <= (qn_r == 3'd1);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_phoneme_id = out_id_r;
  assign out_position   = out_pos_r;
  assign out_last       = out_last_r;

  a_emit_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT) |-> (qn_r != 3'd0))
    else $error("emitting from an empty queue");

  a_done_in_srch: assert property (@(posedge clk) disable iff (!rst_n)
    srch_res.done |-> (state_r == ST_SRCH))
    else $error("lookup result outside the search state");

  a_start_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && (in_cmd == CMD_START)) |=> (wc_r == '0))
    else $error("start item did not clear the id count");

endmodule

[bench/phoneme_codepoint_to_id_framer_core_tb.sv]
`timescale 1ns / 1ps

module phoneme_codepoint_to_id_framer_core_tb;
  import pcf_pkg::*;

  // Command codes the block must ignore
  localparam logic [CMD_W-1:0] CMD_RSVD_LO = 3'd5;
  localparam logic [CMD_W-1:0] CMD_RSVD_HI = 3'd7;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES   = 60;
  localparam int HOLD_CYCLES    = 400;
  localparam int NUM_PHASES     = 8;
  localparam int PHASE_ITEMS    = 8;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [BYTE_W-1:0] data_byte;
    logic [BYTE_W-1:0] punct;
    logic [BYTE_W-1:0] idx;
    logic [CP_W-1:0]   cp;
    logic [ID_W-1:0]   eid;
  } frame_item_t;

  typedef struct packed {
    logic [ID_W-1:0]  pid;
    logic [POS_W-1:0] pos;
    logic             last;
  } id_word_t;

  // Mirror of the framer: table, registers, decoder and id count
  class id_frame_scoreboard;
    logic [CP_W-1:0] key_tab [TABLE_DEPTH_DEF];
    logic [ID_W-1:0] id_tab [TABLE_DEPTH_DEF];
    int unsigned     table_size;
    int unsigned     max_ids;
    int unsigned     id_count;
    int unsigned     accum;
    int unsigned     cont_left;
    bit              in_paren;
    id_word_t        pending_ids [$];
    id_word_t        batch [$];
    int unsigned     mismatches;

    function new();
      table_size = 0;
      max_ids    = 65535;
      id_count   = 0;
      accum      = 0;
      cont_left  = 0;
      in_paren   = 1'b0;
      mismatches = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == CFG_TABLE_SIZE) begin
        table_size = data[TS_W-1:0];
      end else if (idx == CFG_MAX_IDS) begin
        max_ids = data;
      end
    endfunction

    // Binary search over the valid part of the table
    function bit lookup(int unsigned cp, output logic [ID_W-1:0] id);
      int unsigned n, lo, hi, mid;
      n  = (table_size > TABLE_DEPTH_DEF) ? TABLE_DEPTH_DEF : table_size;
      lo = 0;
      hi = n;
      id = ID_PAD;
      while (lo < hi) begin
        mid = (lo + hi) / 2;
        if (key_tab[mid] < cp) lo = mid + 1;
        else hi = mid;
      end
      if (lo < n && key_tab[lo] == cp) begin
        id = id_tab[lo];
        return 1'b1;
      end
      return 1'b0;
    endfunction

    function void push_id(logic [ID_W-1:0] id);
      id_word_t w;
      w.pid  = id;
      w.pos  = id_count[POS_W-1:0];
      w.last = 1'b0;
      batch.push_back(w);
      id_count = (id_count + 1) & 'hFFFF;
    endfunction

    // Emit an id and its pad only when both fit
    function void push_pair(logic [ID_W-1:0] id);
      if (id_count + 2 <= max_ids) begin
        push_id(id);
        push_id(ID_PAD);
      end
    endfunction

    function void take_cp(int unsigned cp);
      logic [ID_W-1:0] id;
      if (cp == CH_LPAREN) in_paren = 1'b1;
      else if (cp == CH_RPAREN) in_paren = 1'b0;
      else if (!in_paren && lookup(cp, id)) push_pair(id);
    endfunction

    // Work out the ids caused by one accepted item
    function void frame_item(frame_item_t it);
      logic [ID_W-1:0]   id;
      logic [BYTE_W-1:0] b;
      logic [BYTE_W-1:0] pc;
      b  = it.data_byte;
      pc = it.punct;
      batch.delete();
      case (it.cmd)
        CMD_START: begin
          id_count  = 0;
          accum     = 0;
          cont_left = 0;
          in_paren  = 1'b0;
          if (max_ids >= 2) begin
            push_id(ID_BOS);
            push_id(ID_PAD);
          end
        end
        CMD_BYTE: begin
          if (cont_left != 0) begin
            accum = ((accum << 6) | b[5:0]) & 'h1FFFFF;
            cont_left--;
            if (cont_left == 0) take_cp(accum);
          end else if (!b[7]) begin
            take_cp(b);
          end else if (b[7:5] == 3'b110) begin
            accum     = b[4:0];
            cont_left = 1;
          end else if (b[7:4] == 4'b1110) begin
            accum     = b[3:0];
            cont_left = 2;
          end else if (b[7:3] == 5'b11110) begin
            accum     = b[2:0];
            cont_left = 3;
          end else begin
            take_cp(b);
          end
        end
        CMD_CLAUSE: begin
          accum     = 0;
          cont_left = 0;
          in_paren  = 1'b0;
          if (pc == CH_PERIOD || pc == CH_COMMA || pc == CH_QUEST ||
              pc == CH_EXCL || pc == CH_COLON || pc == CH_SEMI) begin
            if (lookup(pc, id)) push_pair(id);
            if ((pc == CH_COMMA || pc == CH_COLON || pc == CH_SEMI) && lookup(CH_SPACE, id))
              push_pair(id);
          end
        end
        CMD_FINISH: begin
          if (id_count + 1 <= max_ids) push_id(ID_EOS);
        end
        CMD_LOAD: begin
          key_tab[it.idx] = it.cp;
          id_tab[it.idx]  = it.eid;
        end
        default: ;
      endcase
      if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
      foreach (batch[i]) pending_ids.push_back(batch[i]);
    endfunction

    // Compare one emitted id with the oldest one waiting
    function void check_id(logic [ID_W-1:0] pid, logic [POS_W-1:0] pos, logic last);
      id_word_t want;
      if (pending_ids.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected id %0d at position %0d, last %0b", pid, pos, last);
        return;
      end
      want = pending_ids.pop_front();
      if (want.pid !== pid || want.pos !== pos || want.last !== last) begin
        mismatches++;
        if (mismatches <= 10)
          $display("id mismatch: expected id %0d pos %0d last %0b, got id %0d pos %0d last %0b",
                   want.pid, want.pos, want.last, pid, pos, last);
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  logic [CMD_W-1:0]      in_cmd;
  logic [BYTE_W-1:0]     in_data_byte;
  logic [BYTE_W-1:0]     in_punctuation_char;
  logic [BYTE_W-1:0]     in_entry_index;
  logic [CP_W-1:0]       in_entry_codepoint;
  logic [ID_W-1:0]       in_entry_id;
  logic                  out_valid;
  logic                  out_ready;
  logic [ID_W-1:0]       out_phoneme_id;
  logic [POS_W-1:0]      out_position;
  logic                  out_last;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  id_frame_scoreboard sb;
  frame_item_t        seen_item;
  int unsigned        n_items = 0;
  int unsigned        src_idle_pct = 0;
  int unsigned        snk_stall_pct = 0;
  int unsigned        quiet_cycles = 0;
  int unsigned        hold_left = 0;
  bit                 pressure_arm = 1'b0;
  bit                 pressure_done = 1'b0;

  // Per phase: table_size write, max_ids write, sender idle and receiver stall
  int unsigned ph_table_size [NUM_PHASES] = '{256, 'h012C, 1, 0, 'hFE11, 511, 128, 200};
  int unsigned ph_max_ids [NUM_PHASES]    = '{65535, 40, 65535, 2, 1, 0, 65535, 23};
  int unsigned ph_src_idle [NUM_PHASES]   = '{0, 76, 0, 18, 0, 76, 0, 18};
  int unsigned ph_snk_stall [NUM_PHASES]  = '{0, 0, 76, 18, 0, 0, 76, 18};

  phoneme_codepoint_to_id_framer_core u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_cmd              (in_cmd),
    .in_data_byte        (in_data_byte),
    .in_punctuation_char (in_punctuation_char),
    .in_entry_index      (in_entry_index),
    .in_entry_codepoint  (in_entry_codepoint),
    .in_entry_id         (in_entry_id),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_phoneme_id      (out_phoneme_id),
    .out_position        (out_position),
    .out_last            (out_last),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Sample all three channels at the rising edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
      if (in_valid && in_ready) begin
        seen_item.cmd       = in_cmd;
        seen_item.data_byte = in_data_byte;
        seen_item.punct     = in_punctuation_char;
        seen_item.idx       = in_entry_index;
        seen_item.cp        = in_entry_codepoint;
        seen_item.eid       = in_entry_id;
        sb.frame_item(seen_item);
      end
      if (out_valid && out_ready) sb.check_id(out_phoneme_id, out_position, out_last);
    end
  end

  // Abort when nothing has moved for too long
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Receiver: random stalls, plus one long hold-off when armed
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_ready = 1'b0;
    end else if (pressure_arm && !pressure_done) begin
      pressure_done = 1'b1;
      hold_left     = HOLD_CYCLES;
      out_ready     = 1'b0;
    end else begin
      out_ready = ($urandom_range(0, 99) >= snk_stall_pct);
    end
  end

  // Offer one item and hold it until accepted; returns at the falling edge
  task automatic put_item(input int unsigned cmd, input int unsigned data,
                          input int unsigned punct, input int unsigned idx,
                          input int unsigned cp, input int unsigned eid);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_cmd              = cmd[CMD_W-1:0];
    in_data_byte        = data[BYTE_W-1:0];
    in_punctuation_char = punct[BYTE_W-1:0];
    in_entry_index      = idx[BYTE_W-1:0];
    in_entry_codepoint  = cp[CP_W-1:0];
    in_entry_id         = eid[ID_W-1:0];
    in_valid            = 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    n_items++;
  endtask

  task automatic put_byte(input int unsigned b);
    put_item(CMD_BYTE, b, $urandom, $urandom, $urandom, $urandom);
  endtask

  task automatic put_clause(input int unsigned p);
    put_item(CMD_CLAUSE, $urandom, p, $urandom, $urandom, $urandom);
  endtask

  task automatic put_plain(input int unsigned cmd);
    put_item(cmd, $urandom, $urandom, $urandom, $urandom, $urandom);
  endtask

  // Encode a codepoint as UTF-8; unless plain, allow overlong forms,
  // bare continuation or invalid lead bytes and odd top bits on continuation bytes
  task automatic send_cp(input int unsigned cp, input bit plain);
    int unsigned len, b;
    len = (cp < 'h80) ? 1 : (cp < 'h800) ? 2 : (cp < 'h10000) ? 3 : 4;
    if (!plain) begin
      if (cp >= 'h80 && cp <= 'hFF && (cp < 'hC0 || cp >= 'hF8) && $urandom_range(0, 2) == 0)
        len = 1;
      else if (len < 4 && $urandom_range(0, 9) == 0)
        len = $urandom_range(len + 1, 4);
    end
    case (len)
      1:       b = cp & 'hFF;
      2:       b = 'hC0 | ((cp >> 6) & 'h1F);
      3:       b = 'hE0 | ((cp >> 12) & 'hF);
      default: b = 'hF0 | ((cp >> 18) & 'h7);
    endcase
    put_byte(b);
    for (int k = len - 2; k >= 0; k--) begin
      b = 'h80 | ((cp >> (6 * k)) & 'h3F);
      if (!plain && $urandom_range(0, 4) == 0) b = (b & 'h3F) | ($urandom_range(0, 3) << 6);
      put_byte(b);
    end
  endtask

  function automatic int unsigned pick_mark();
    case ($urandom_range(0, 7))
      0:       return CH_PERIOD;
      1:       return CH_COMMA;
      2:       return CH_QUEST;
      3:       return CH_EXCL;
      4:       return CH_COLON;
      5:       return CH_SEMI;
      default: return $urandom_range(0, 255);
    endcase
  endfunction

  task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned data);
    cfg_index = idx;
    cfg_data  = data[CFG_DATA_W-1:0];
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Drop valid, drain every expected id, then let the block go quiet
  task automatic settle();
    in_valid = 1'b0;
    while (sb.pending_ids.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  initial begin
    int unsigned tab_key [TABLE_DEPTH_DEF];
    int unsigned low_n, s, s2, s3, base, top, cnt, step;
    int unsigned r, slot, eff, lo, hi, cp, len, mark, n_chars;

    sb                  = new();
    rst_n               = 1'b0;
    in_valid            = 1'b0;
    in_cmd              = CMD_START;
    in_data_byte        = '0;
    in_punctuation_char = '0;
    in_entry_index      = '0;
    in_entry_codepoint  = '0;
    in_entry_id         = '0;
    out_ready           = 1'b1;
    cfg_valid           = 1'b0;
    cfg_index           = CFG_TABLE_SIZE;
    cfg_data            = '0;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    // Build a sorted table: most low bytes (space and punctuation always),
    // then bands of two-, three- and four-byte codepoints
    low_n = 0;
    for (int v = 0; v < 256; v++) begin
      if (v == 0 || (v >= CH_SPACE && v <= CH_QUEST) || v == 'h80 || v == 'hC0 ||
          v == 'hFF || $urandom_range(0, 99) < 60) begin
        tab_key[low_n] = v;
        low_n++;
      end
    end
    s = low_n;
    for (int band = 0; band < 3; band++) begin
      case (band)
        0: begin
          base = 'h100;
          top  = 'h800;
          cnt  = (TABLE_DEPTH_DEF - low_n) / 3;
        end
        1: begin
          base = 'h800;
          top  = 'h10000;
          cnt  = (TABLE_DEPTH_DEF - low_n) / 3;
        end
        default: begin
          base = 'h10000;
          top  = 'h110000;
          cnt  = TABLE_DEPTH_DEF - s;
        end
      endcase
      step = (top - base) / cnt;
      for (int k = 0; k < cnt; k++) begin
        tab_key[s] = base + k * step + $urandom_range(0, step - 1);
        s++;
      end
    end
    tab_key[TABLE_DEPTH_DEF - 1] = 'h10FFFF;
    s2 = low_n;
    s3 = low_n + (TABLE_DEPTH_DEF - low_n) / 3;
    for (int i = 0; i < TABLE_DEPTH_DEF; i++)
      put_item(CMD_LOAD, $urandom, $urandom, i, tab_key[i], $urandom_range(0, 1023));

    for (int p = 0; p < NUM_PHASES; p++) begin
      settle();
      set_reg(CFG_TABLE_SIZE, ph_table_size[p]);
      set_reg(CFG_MAX_IDS, ph_max_ids[p]);
      src_idle_pct  = ph_src_idle[p];
      snk_stall_pct = ph_snk_stall[p];
      eff = (sb.table_size > TABLE_DEPTH_DEF) ? TABLE_DEPTH_DEF : sb.table_size;

      if (p == 0) begin
        // Finish before any start, then a sentence through the odd corners
        put_plain(CMD_FINISH);
        put_plain(CMD_START);
        send_cp(0, 1'b1);
        put_byte(CH_LPAREN);
        put_byte('hFF);
        put_byte(CH_RPAREN);
        send_cp(sb.key_tab[s2], 1'b1);
        send_cp(sb.key_tab[s3], 1'b1);
        send_cp('h10FFFF, 1'b1);
        put_byte('h80);
        put_byte('hC3);
        put_byte('h00);
        put_byte('hE2);
        put_byte('h82);
        put_clause(CH_COMMA);
        put_clause(CH_PERIOD);
        put_clause(CH_COLON);
        put_clause(CH_SEMI);
        put_clause(0);
        put_plain(CMD_RSVD_HI);
        put_plain(CMD_FINISH);
        pressure_arm = 1'b1;
      end

      // Mostly well-formed sentences with random content and some noise
      mark = n_items;
      while (n_items - mark < PHASE_ITEMS) begin
        if ($urandom_range(0, 9) != 0) put_plain(CMD_START);
        n_chars = $urandom_range(1, 14);
        for (int c = 0; c < n_chars; c++) begin
          r = $urandom_range(0, 99);
          if (r < 8) begin
            put_byte(CH_LPAREN);
          end else if (r < 16) begin
            put_byte(CH_RPAREN);
          end else if (r < 62) begin
            slot = (eff == 0) ? $urandom_range(0, 255) : $urandom_range(0, eff - 1);
            send_cp(sb.key_tab[slot], 1'b0);
          end else if (r < 76) begin
            len = $urandom_range(1, 4);
            case (len)
              1:       cp = $urandom_range(0, 'h7F);
              2:       cp = $urandom_range('h80, 'h7FF);
              3:       cp = $urandom_range('h800, 'hFFFF);
              default: cp = $urandom_range('h10000, 'h1FFFFF);
            endcase
            send_cp(cp, 1'b0);
          end else if (r < 84) begin
            put_byte($urandom_range(0, 255));
          end else if (r < 90) begin
            // Broken sequence: a lead byte short of its continuation bytes
            put_byte($urandom_range('hC0, 'hF7));
            repeat ($urandom_range(0, 2)) put_byte($urandom_range(0, 255));
          end else if (r < 96) begin
            put_clause(pick_mark());
          end else if (r < 98) begin
            // Reload one slot, keeping the table strictly ascending
            slot = $urandom_range(0, 255);
            lo   = (slot == 0) ? 0 : sb.key_tab[slot - 1] + 1;
            hi   = (slot == 255) ? 'h10FFFF : sb.key_tab[slot + 1] - 1;
            cp   = (lo <= hi) ? $urandom_range(lo, hi) : sb.key_tab[slot];
            put_item(CMD_LOAD, $urandom, $urandom, slot, cp, $urandom_range(0, 1023));
          end else begin
            put_plain($urandom_range(CMD_RSVD_LO, CMD_RSVD_HI));
          end
        end
        if ($urandom_range(0, 9) != 0) put_clause(pick_mark());
        if ($urandom_range(0, 99) < 85) put_plain(CMD_FINISH);
      end
    end

    settle();
    if (sb.mismatches == 0 && sb.pending_ids.size() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
